// File: hw/rtl/xxtea_keyed_xor_decrypt_top_defines.svh
// Assertion macros for the keyed XOR decryptor top level.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef XXTEA_KEYED_XOR_DECRYPT_TOP_DEFINES_SVH
`define XXTEA_KEYED_XOR_DECRYPT_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define XKXD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define XKXD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/xkxd_pkg.sv
// Shared types and constants for the keyed XOR decryptor.
// No dependencies; used by xkxd_ctrl, xkxd_dp and the top level.
package xkxd_pkg;

    localparam int KEY_WORDS   = 1024;
    localparam int FULL_WORDS  = 512;
    localparam int STRIDE      = 64;
    localparam int ROUNDS      = 6;
    localparam int CHECK_WORDS = 128;
    localparam int KEY_PARTS   = 4;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = $clog2(KEY_PARTS);
    localparam int IDX_W     = $clog2(KEY_WORDS);
    localparam int POS_W     = (FULL_WORDS > 0) ? $clog2(FULL_WORDS + 1) : 1;
    localparam int STRIDE_W  = (STRIDE > 1) ? $clog2(STRIDE) : 1;
    localparam int CNT_W     = $clog2(CHECK_WORDS + 1);
    localparam int ROUND_W   = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    localparam logic [DATA_W-1:0] XX_DELTA = 32'h9e37_79b9;

    typedef struct packed {
        logic [DATA_W-1:0] cipher_word;
        logic              first_word;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] plain_word;
        logic [DATA_W-1:0] running_check;
    } t_out_item;

    // Datapath operation issued by the controller each cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_DEC_RD,
        OP_DEC_HOLD,
        OP_DEC_WR,
        OP_ZRD,
        OP_ZCAP,
        OP_RD0,
        OP_RD1,
        OP_MIX,
        OP_WR
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEC_RD,
        ST_DEC_WR,
        ST_EX_ZRD,
        ST_EX_ZCAP,
        ST_EX_RD0,
        ST_EX_RD1,
        ST_EX_MIX,
        ST_EX_WR
    } t_state;

    typedef struct packed {
        logic clear_last;
        logic step_last;
        logic round_last;
        logic table_valid;
        logic first;
    } t_status;

endpackage

// File: hw/rtl/xkxd_ctrl.sv
// Sequencer for the keyed XOR decryptor: table clear, key expansion, decode.
// Depends on xkxd_pkg; drives the datapath xkxd_dp through t_op.
module xkxd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  xkxd_pkg::t_status i_status,
    output xkxd_pkg::t_op    o_op
);

    xkxd_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xkxd_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_op        = xkxd_pkg::OP_NONE;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            xkxd_pkg::ST_CLEAR: begin
                o_op = xkxd_pkg::OP_CLEAR;
                if (i_status.clear_last) begin
                    n_state = xkxd_pkg::ST_IDLE;
                end
            end
            xkxd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_op    = xkxd_pkg::OP_ACCEPT;
                    n_state = xkxd_pkg::ST_DEC_RD;
                end
            end
            xkxd_pkg::ST_DEC_RD: begin
                // buffer start on a stale table: expand first
                if (i_status.first && !i_status.table_valid) begin
                    n_state = xkxd_pkg::ST_EX_ZRD;
                end else begin
                    o_op    = xkxd_pkg::OP_DEC_RD;
                    n_state = xkxd_pkg::ST_DEC_WR;
                end
            end
            xkxd_pkg::ST_DEC_WR: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_op        = xkxd_pkg::OP_DEC_WR;
                    n_out_valid = 1'b1;
                    n_state     = xkxd_pkg::ST_IDLE;
                end else begin
                    o_op = xkxd_pkg::OP_DEC_HOLD;
                end
            end
            xkxd_pkg::ST_EX_ZRD: begin
                o_op    = xkxd_pkg::OP_ZRD;
                n_state = xkxd_pkg::ST_EX_ZCAP;
            end
            xkxd_pkg::ST_EX_ZCAP: begin
                o_op    = xkxd_pkg::OP_ZCAP;
                n_state = xkxd_pkg::ST_EX_RD0;
            end
            xkxd_pkg::ST_EX_RD0: begin
                o_op    = xkxd_pkg::OP_RD0;
                n_state = xkxd_pkg::ST_EX_RD1;
            end
            xkxd_pkg::ST_EX_RD1: begin
                o_op    = xkxd_pkg::OP_RD1;
                n_state = xkxd_pkg::ST_EX_MIX;
            end
            xkxd_pkg::ST_EX_MIX: begin
                o_op    = xkxd_pkg::OP_MIX;
                n_state = xkxd_pkg::ST_EX_WR;
            end
            xkxd_pkg::ST_EX_WR: begin
                o_op = xkxd_pkg::OP_WR;
                if (i_status.step_last && i_status.round_last) begin
                    n_state = xkxd_pkg::ST_DEC_RD;
                end else begin
                    n_state = xkxd_pkg::ST_EX_RD0;
                end
            end
            default: begin
                n_state = xkxd_pkg::ST_CLEAR;
            end
        endcase
    end

    assign o_in_stall  = (r_state != xkxd_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/xkxd_dp.sv
// Datapath of the keyed XOR decryptor: key table memory, XXTEA round unit,
// decode counters, checksum and output register. Depends on xkxd_pkg.
module xkxd_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [xkxd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [xkxd_pkg::DATA_W-1:0]         i_cfg_data,
    input  xkxd_pkg::t_in_item                  i_in_item,
    input  xkxd_pkg::t_op                       i_op,
    output xkxd_pkg::t_status                   o_status,
    output xkxd_pkg::t_out_item                 o_out_item
);

    localparam int DW = xkxd_pkg::DATA_W;
    localparam int IW = xkxd_pkg::IDX_W;
    localparam int PW = xkxd_pkg::POS_W;
    localparam int SW = xkxd_pkg::STRIDE_W;
    localparam int CW = xkxd_pkg::CNT_W;
    localparam int RW = xkxd_pkg::ROUND_W;

    function automatic logic [DW-1:0] mix(input logic [DW-1:0] y, input logic [DW-1:0] z,
                                          input logic [DW-1:0] sum,
                                          input logic [DW-1:0] key);
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (sum ^ y) + (key ^ z);
        return a ^ b;
    endfunction

    // key table memory
    logic [DW-1:0] r_table [xkxd_pkg::KEY_WORDS];
    logic [DW-1:0] r_rd_data;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [DW-1:0] wr_data;

    // key registers and table state
    logic [DW-1:0] r_key [xkxd_pkg::KEY_PARTS];
    logic          r_valid;

    // expansion state
    logic [IW-1:0] r_step;
    logic [RW-1:0] r_round;
    logic [DW-1:0] r_sum;
    logic [DW-1:0] r_z;
    logic [DW-1:0] r_x;
    logic [DW-1:0] r_mix;
    logic [1:0]    key_sel;
    logic [DW-1:0] new_word;
    logic [IW-1:0] step_inc;
    logic          step_last;
    logic          round_last;

    // decode state
    xkxd_pkg::t_in_item  r_in;
    xkxd_pkg::t_out_item r_out;
    logic [PW-1:0] r_pos;
    logic [SW-1:0] r_stride;
    logic [IW-1:0] r_index;
    logic [DW-1:0] r_acc;
    logic [CW-1:0] r_cnt;

    logic [PW-1:0] pos_eff;
    logic [SW-1:0] stride_eff;
    logic [IW-1:0] index_eff;
    logic [DW-1:0] acc_eff;
    logic [CW-1:0] cnt_eff;
    logic          in_full;
    logic          xor_en;
    logic [DW-1:0] plain;
    logic [PW-1:0] n_pos;
    logic [SW-1:0] n_stride;
    logic [IW-1:0] n_index;
    logic [DW-1:0] n_acc;
    logic [CW-1:0] n_cnt;

    assign step_last  = (r_step == IW'(xkxd_pkg::KEY_WORDS - 1));
    assign round_last = (r_round == RW'(xkxd_pkg::ROUNDS - 1));
    assign step_inc   = step_last ? '0 : r_step + 1'b1;
    assign key_sel    = r_step[1:0] ^ r_sum[3:2];
    assign new_word   = r_x + r_mix;

    // decode: a buffer start restarts every counter
    always_comb begin
        pos_eff    = r_in.first_word ? '0 : r_pos;
        stride_eff = r_in.first_word ? '0 : r_stride;
        index_eff  = r_in.first_word ? '0 : r_index;
        acc_eff    = r_in.first_word ? '0 : r_acc;
        cnt_eff    = r_in.first_word ? '0 : r_cnt;
        in_full    = (pos_eff < PW'(xkxd_pkg::FULL_WORDS));
        xor_en     = in_full || (stride_eff == '0);
        plain      = r_in.cipher_word ^ (xor_en ? r_rd_data : '0);
        if (in_full) begin
            n_pos    = pos_eff + 1'b1;
            n_stride = stride_eff;
        end else begin
            n_pos    = pos_eff;
            n_stride = (stride_eff == SW'(xkxd_pkg::STRIDE - 1)) ? '0 : stride_eff + 1'b1;
        end
        if (xor_en) begin
            n_index = (index_eff == IW'(xkxd_pkg::KEY_WORDS - 1)) ? '0 : index_eff + 1'b1;
        end else begin
            n_index = index_eff;
        end
        if (cnt_eff < CW'(xkxd_pkg::CHECK_WORDS)) begin
            n_acc = acc_eff ^ plain;
            n_cnt = cnt_eff + 1'b1;
        end else begin
            n_acc = acc_eff;
            n_cnt = cnt_eff;
        end
    end

    always_comb begin
        unique case (i_op)
            xkxd_pkg::OP_ZRD:  rd_addr = IW'(xkxd_pkg::KEY_WORDS - 1);
            xkxd_pkg::OP_RD1:  rd_addr = step_inc;
            xkxd_pkg::OP_DEC_RD,
            xkxd_pkg::OP_DEC_HOLD,
            xkxd_pkg::OP_DEC_WR: rd_addr = index_eff;
            default:           rd_addr = r_step;
        endcase
        wr_en   = (i_op == xkxd_pkg::OP_CLEAR) || (i_op == xkxd_pkg::OP_WR);
        wr_data = (i_op == xkxd_pkg::OP_WR) ? new_word : '0;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[r_step] <= wr_data;
        end
        r_rd_data <= r_table[rd_addr];
    end

    // control counters and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_round  <= '0;
            r_valid  <= 1'b0;
            r_pos    <= '0;
            r_stride <= '0;
            r_index  <= '0;
            r_cnt    <= '0;
            r_acc    <= '0;
            for (int k = 0; k < xkxd_pkg::KEY_PARTS; k++) begin
                r_key[k] <= '0;
            end
        end else begin
            unique case (i_op)
                xkxd_pkg::OP_CLEAR: begin
                    r_step <= step_inc;
                end
                xkxd_pkg::OP_ZCAP: begin
                    r_step  <= '0;
                    r_round <= '0;
                end
                xkxd_pkg::OP_WR: begin
                    r_step <= step_inc;
                    if (step_last) begin
                        if (round_last) begin
                            r_valid <= 1'b1;
                        end else begin
                            r_round <= r_round + 1'b1;
                        end
                    end
                end
                xkxd_pkg::OP_DEC_WR: begin
                    r_pos    <= n_pos;
                    r_stride <= n_stride;
                    r_index  <= n_index;
                    r_acc    <= n_acc;
                    r_cnt    <= n_cnt;
                end
                default: begin
                end
            endcase
            // a changed key part makes the table stale
            if (i_cfg_we && (r_key[i_cfg_index] != i_cfg_data)) begin
                r_key[i_cfg_index] <= i_cfg_data;
                r_valid            <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            xkxd_pkg::OP_ACCEPT: begin
                r_in <= i_in_item;
            end
            xkxd_pkg::OP_ZCAP: begin
                r_z   <= r_rd_data;
                r_sum <= xkxd_pkg::XX_DELTA;
            end
            xkxd_pkg::OP_RD1: begin
                r_x <= r_rd_data;
            end
            xkxd_pkg::OP_MIX: begin
                r_mix <= mix(r_rd_data, r_z, r_sum, r_key[key_sel]);
            end
            xkxd_pkg::OP_WR: begin
                r_z <= new_word;
                if (step_last && !round_last) begin
                    r_sum <= r_sum + xkxd_pkg::XX_DELTA;
                end
            end
            xkxd_pkg::OP_DEC_WR: begin
                r_out.plain_word    <= plain;
                r_out.running_check <= n_acc;
            end
            default: begin
            end
        endcase
    end

    assign o_status.clear_last  = step_last;
    assign o_status.step_last   = step_last;
    assign o_status.round_last  = round_last;
    assign o_status.table_valid = r_valid;
    assign o_status.first       = r_in.first_word;
    assign o_out_item           = r_out;

endmodule

// File: hw/rtl/xxtea_keyed_xor_decrypt_top.sv
// Keyed XOR stream decryptor. Each 32-bit word passes accept, table read and
// result, the result step waiting while the output register is held full; the
// next word is accepted while a finished result still waits. A buffer start
// (first_word) on a stale table first runs the XXTEA expansion over the
// 1024-word table. The table memory has a single read port, so one step
// reads two words in turn, mixes and writes back. After reset a clearing pass
// zeroes the table while the input is stalled; key writes are taken at any
// time. Uses xkxd_pkg, xkxd_ctrl, xkxd_dp and
// xxtea_keyed_xor_decrypt_top_defines.svh.
`include "xxtea_keyed_xor_decrypt_top_defines.svh"

module xxtea_keyed_xor_decrypt_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [xkxd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [xkxd_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  xkxd_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output xkxd_pkg::t_out_item            o_out_item
);

    xkxd_pkg::t_op     op;
    xkxd_pkg::t_status status;

    xkxd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_op        (op)
    );

    xkxd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_op        (op),
        .o_status    (status),
        .o_out_item  (o_out_item)
    );

    // one transaction in flight at a time
    `XKXD_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall, "second transaction accepted while busy")
    // a result is loaded only into a free output register
    `XKXD_ASSERT_NOW(a_no_overwrite, op == xkxd_pkg::OP_DEC_WR, !o_out_valid || !i_out_stall, "output overwritten while stalled")
    // finishing the expansion leaves the table valid
    `XKXD_ASSERT_NEXT(a_expand_valid, op == xkxd_pkg::OP_WR && status.step_last && status.round_last && !i_cfg_we, status.table_valid, "table not valid after expansion")

endmodule
